// ===== hdl/start_button_mode_controller_assert.svh =====
// Assertion macros used by the mode machine of the start button mode controller RTL.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef START_BUTTON_MODE_CONTROLLER_ASSERT_SVH
`define START_BUTTON_MODE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, ignored while in reset.
`define SBMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset.
`define SBMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sbmc_pkg.sv =====
// Shared types and constants for the start button mode controller.
// No dependencies; used by every module of the block.
package sbmc_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DEBOUNCE_W = 10;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET_MS = 10'd50;

  typedef enum logic [1:0] {
    MODE_WAIT  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_ESTOP = 2'd2,
    MODE_LINK  = 2'd3
  } sbmc_mode_t;

  // Debounced button information for one transaction.
  typedef struct packed {
    logic press;   // accepted press (edge that passed the spacing rule)
    logic stable;  // debounced level after this transaction
  } sbmc_btn_t;

  // One-transaction action pulses.
  typedef struct packed {
    logic resume;
    logic estop;
    logic restart;
    logic start;
  } sbmc_pulse_t;

endpackage

// ===== hdl/start_button_mode_controller.sv =====
// Top level of the start button mode controller: input register, debounce
// and mode logic, result register. Depends on sbmc_pkg, sbmc_debounce, sbmc_mode_fsm.
//
//  channel   direction  width  contents
//  s_axis    in         40     now_ms, raw/fault/link/pause/phase flags
//  m_axis    out        8      mode, four action pulses, debounced level
//  cfg       in         10     debounce_ms, write-only
//
// One transaction per clock sustained while the output is not stalled: a transaction is held in the input
// register, then debounce and mode logic settle in one pass into the output register.
// Reset (rst, synchronous) empties both registers, restores debounce_ms to 50 and
// returns the controller to wait start with all timestamps at zero.
// A stalled output holds its result and lets the input register take one more
// transaction; state advances only when a result moves to the output.
module start_button_mode_controller (
  input  logic                                clk,
  input  logic                                rst,
  // from bit 0 up: now_ms[31:0], raw_pressed, speed_fault, lead_lost,
  //  meas_pause, lost_phase, zero pad
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sbmc_pkg::IN_DATA_W-1:0]      s_tdata,
  // from bit 0 up: mode[1:0], start_pulse, restart_pulse, estop_pulse,
  //  resume_pulse, button_stable, zero pad
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sbmc_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_wr_en,
  input  logic [sbmc_pkg::DEBOUNCE_W-1:0]     cfg_wr_data
);

  logic [sbmc_pkg::DEBOUNCE_W-1:0] debounce_ms;

  // Input register.
  logic                        in_valid;
  logic [sbmc_pkg::TIME_W-1:0] in_now_ms;
  logic                        in_raw_pressed;
  logic                        in_speed_fault;
  logic                        in_lead_lost;
  logic                        in_meas_pause;
  logic                        in_lost_phase;

  logic                        advance;
  sbmc_pkg::sbmc_btn_t         btn;
  sbmc_pkg::sbmc_mode_t        mode_next;
  sbmc_pkg::sbmc_pulse_t       pulses;

  // Advance when the input register is full and the output can take it.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= sbmc_pkg::DEBOUNCE_RESET_MS;
    end else if (cfg_wr_en) begin
      debounce_ms <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Payload: capture on every accepted transaction, no reset needed.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_now_ms      <= s_tdata[31:0];
      in_raw_pressed <= s_tdata[32];
      in_speed_fault <= s_tdata[33];
      in_lead_lost   <= s_tdata[34];
      in_meas_pause  <= s_tdata[35];
      in_lost_phase  <= s_tdata[36];
    end
  end

  sbmc_debounce u_debounce (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .now_ms      (in_now_ms),
    .raw_pressed (in_raw_pressed),
    .debounce_ms (debounce_ms),
    .btn         (btn)
  );

  sbmc_mode_fsm u_mode_fsm (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .btn         (btn),
    .speed_fault (in_speed_fault),
    .lead_lost   (in_lead_lost),
    .meas_pause  (in_meas_pause),
    .lost_phase  (in_lost_phase),
    .mode_next   (mode_next),
    .pulses      (pulses)
  );

  // Output register: hold while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {1'b0, btn.stable, pulses.resume, pulses.estop,
                  pulses.restart, pulses.start, mode_next};
    end
  end

endmodule

// ===== hdl/sbmc_debounce.sv =====
// Debounce, edge detect and press spacing for the START button.
// Depends on sbmc_pkg.
module sbmc_debounce (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic [sbmc_pkg::TIME_W-1:0]         now_ms,
  input  logic                                raw_pressed,
  input  logic [sbmc_pkg::DEBOUNCE_W-1:0]     debounce_ms,
  output sbmc_pkg::sbmc_btn_t                 btn
);

  logic                        raw_last;
  logic                        stable_level;
  logic                        prev_stable;
  logic [sbmc_pkg::TIME_W-1:0] change_time;
  logic [sbmc_pkg::TIME_W-1:0] accept_time;

  logic                        raw_changed;
  logic [sbmc_pkg::TIME_W-1:0] since_change;
  logic [sbmc_pkg::TIME_W-1:0] since_accept;
  logic [sbmc_pkg::TIME_W-1:0] hold_time;
  logic [sbmc_pkg::TIME_W-1:0] space_time;
  logic                        stable_next;
  logic                        rise;

  assign raw_changed  = raw_pressed != raw_last;
  assign since_change = now_ms - change_time;
  assign since_accept = now_ms - accept_time;
  assign hold_time    = {{(sbmc_pkg::TIME_W - sbmc_pkg::DEBOUNCE_W){1'b0}}, debounce_ms};
  assign space_time   = {{(sbmc_pkg::TIME_W - sbmc_pkg::DEBOUNCE_W - 1){1'b0}},
                         debounce_ms, 1'b0};

  // Level follows the held raw value once it has been steady long enough.
  assign stable_next = (!raw_changed && (since_change >= hold_time)) ? raw_last : stable_level;
  assign rise        = stable_next && !prev_stable;

  assign btn.press  = rise && (since_accept >= space_time);
  assign btn.stable = stable_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_last     <= 1'b0;
      stable_level <= 1'b0;
      prev_stable  <= 1'b0;
      change_time  <= '0;
      accept_time  <= '0;
    end else if (advance) begin
      stable_level <= stable_next;
      prev_stable  <= stable_next;
      if (raw_changed) begin
        raw_last    <= raw_pressed;
        change_time <= now_ms;
      end
      if (btn.press) begin
        accept_time <= now_ms;
      end
    end
  end

endmodule

// ===== hdl/sbmc_mode_fsm.sv =====
// Four-state mode machine: wait start, running, estop, link lost.
// Depends on sbmc_pkg and start_button_mode_controller_assert.svh.
`include "start_button_mode_controller_assert.svh"

module sbmc_mode_fsm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  sbmc_pkg::sbmc_btn_t   btn,
  input  logic                  speed_fault,
  input  logic                  lead_lost,
  input  logic                  meas_pause,
  input  logic                  lost_phase,
  output sbmc_pkg::sbmc_mode_t  mode_next,
  output sbmc_pkg::sbmc_pulse_t pulses
);

  sbmc_pkg::sbmc_mode_t mode_q;
  sbmc_pkg::sbmc_mode_t mode_press;
  logic                 started;
  logic                 started_next;
  logic                 lost_eff;
  logic                 estop_held;

  assign estop_held = (mode_q == sbmc_pkg::MODE_ESTOP);

  // Next state: press handling, then fault, then link loss.
  always_comb begin
    mode_press = mode_q;
    lost_eff   = lead_lost;
    if (btn.press) begin
      unique case (mode_q)
        sbmc_pkg::MODE_WAIT: begin
          mode_press = sbmc_pkg::MODE_RUN;
        end
        sbmc_pkg::MODE_RUN: begin
          if (!lost_phase) begin
            mode_press = sbmc_pkg::MODE_ESTOP;
          end
        end
        sbmc_pkg::MODE_LINK: begin
          mode_press = sbmc_pkg::MODE_RUN;
          lost_eff   = 1'b0;
        end
        default: begin
          mode_press = mode_q;
        end
      endcase
    end
    mode_next = mode_press;
    if (mode_next == sbmc_pkg::MODE_RUN && speed_fault) begin
      mode_next = sbmc_pkg::MODE_ESTOP;
    end
    if (mode_next == sbmc_pkg::MODE_RUN && lost_eff && meas_pause) begin
      mode_next = sbmc_pkg::MODE_LINK;
    end
  end

  // Outputs: action pulses and the first-start flag.
  always_comb begin
    pulses       = '0;
    started_next = started;
    if (btn.press) begin
      unique case (mode_q)
        sbmc_pkg::MODE_WAIT: begin
          if (!started) begin
            pulses.start = 1'b1;
            started_next = 1'b1;
          end else begin
            pulses.restart = 1'b1;
          end
        end
        sbmc_pkg::MODE_RUN: begin
          pulses.estop = !lost_phase;
        end
        sbmc_pkg::MODE_LINK: begin
          pulses.resume = 1'b1;
        end
        default: begin
          pulses = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q  <= sbmc_pkg::MODE_WAIT;
      started <= 1'b0;
    end else if (advance) begin
      mode_q  <= mode_next;
      started <= started_next;
    end
  end

  `SBMC_ASSERT_NEXT(a_estop_latched, estop_held, estop_held, "estop mode left without reset")
  `SBMC_ASSERT_NOW(a_start_once, pulses.start, !started, "start pulse after first start")
  `SBMC_ASSERT_NOW(a_one_pulse, 1'b1, $onehot0(pulses), "several action pulses at once")

endmodule
